>>> hdl/rpt_pkg.sv
// shared types and codes for the rectangle placement table
// no dependencies; used by every module under hdl

package rpt_pkg;

    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_OUTSIDE = 3'd2;
    localparam logic [2:0] ST_EDGE    = 3'd3;
    localparam logic [2:0] ST_OVERLAP = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    localparam int TALLY_W = 16;
    localparam int FIELD_W = 6;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FIELD_W-1:0] origin_x;
        logic [FIELD_W-1:0] origin_y;
        logic [FIELD_W-1:0] span_w;
        logic [FIELD_W-1:0] span_h;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [FIELD_W-1:0] stored_count;
        logic [TALLY_W-1:0] rejected_count;
    } rsp_t;

    typedef struct packed {
        logic [FIELD_W-1:0] h;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] x;
    } rect_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan;
        logic       finish;
        logic [2:0] fin_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       is_clear;
        logic       is_place;
        logic [2:0] basic;
        logic       full;
        logic       hit;
        logic       drained;
    } dp_stat_t;

endpackage

>>> hdl/rpt_cfg.sv
// apb register file for grid columns and rows, with write clamping
// depends on rpt_pkg

module rpt_cfg #(
    parameter int MAX_GRID = 32,
    parameter int MIN_GRID = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [rpt_pkg::FIELD_W-1:0] grid_columns,
    output logic [rpt_pkg::FIELD_W-1:0] grid_rows
);

    localparam int GRID_RST = (32 > MAX_GRID) ? MAX_GRID : 32;
    localparam logic [rpt_pkg::FIELD_W-1:0] MIN_V = rpt_pkg::FIELD_W'(MIN_GRID);
    localparam logic [rpt_pkg::FIELD_W-1:0] MAX_V = rpt_pkg::FIELD_W'(MAX_GRID);
    localparam logic [rpt_pkg::FIELD_W-1:0] RST_V = rpt_pkg::FIELD_W'(GRID_RST);

    logic [rpt_pkg::FIELD_W-1:0] cols_reg;
    logic [rpt_pkg::FIELD_W-1:0] rows_reg;
    logic [rpt_pkg::FIELD_W-1:0] wval;
    logic [rpt_pkg::FIELD_W-1:0] clamped;
    logic                        wr;

    assign wr     = psel & penable & pwrite;
    assign wval   = pwdata[rpt_pkg::FIELD_W-1:0];
    assign pready = 1'b1;

    always_comb
    begin
        if (32'(wval) < MIN_GRID)
            clamped = MIN_V;
        else if (32'(wval) > MAX_GRID)
            clamped = MAX_V;
        else
            clamped = wval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= RST_V;
            rows_reg <= RST_V;
        end
        else if (wr)
        begin
            // word decode: register index is address bit 2
            if (paddr[2])
                rows_reg <= clamped;
            else
                cols_reg <= clamped;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2])
            prdata[rpt_pkg::FIELD_W-1:0] = rows_reg;
        else
            prdata[rpt_pkg::FIELD_W-1:0] = cols_reg;
    end

    assign grid_columns = cols_reg;
    assign grid_rows    = rows_reg;

endmodule

>>> hdl/rpt_dp.sv
// datapath: request register, rectangle memory, scan pipeline, counters, result register
// depends on rpt_pkg; driven by rpt_ctrl through ctrl_cmd_t

module rpt_dp #(
    parameter int MAX_RECTS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpt_pkg::req_t               req,
    input  logic [rpt_pkg::FIELD_W-1:0] grid_columns,
    input  logic [rpt_pkg::FIELD_W-1:0] grid_rows,
    input  rpt_pkg::ctrl_cmd_t          cmd,
    output rpt_pkg::dp_stat_t           stat,
    output logic                        done,
    output rpt_pkg::rsp_t               rsp
);

    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);
    localparam logic [rpt_pkg::TALLY_W-1:0] TALLY_SAT = '1;
    localparam int SUM_W = rpt_pkg::FIELD_W + 1;

    rpt_pkg::req_t  req_reg;
    rpt_pkg::rect_t mem [MAX_RECTS];
    rpt_pkg::rect_t rd_reg;
    rpt_pkg::rsp_t  rsp_reg;
    logic [CNT_W-1:0]            ptr_reg;
    logic                        cmp_v_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [rpt_pkg::TALLY_W-1:0] tally_reg;
    logic [rpt_pkg::TALLY_W-1:0] tally_next;
    logic                        done_reg;
    logic                        iss;
    logic                        crossed;
    logic                        commit;
    logic [2:0]                  basic;
    logic [SUM_W-1:0]            rx_end;
    logic [SUM_W-1:0]            ry_end;
    logic [SUM_W-1:0]            ex_end;
    logic [SUM_W-1:0]            ey_end;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
    end

    // range checks on the held request
    assign rx_end = SUM_W'(req_reg.origin_x) + SUM_W'(req_reg.span_w);
    assign ry_end = SUM_W'(req_reg.origin_y) + SUM_W'(req_reg.span_h);

    always_comb
    begin
        if (req_reg.span_w == '0 || req_reg.span_h == '0)
            basic = rpt_pkg::ST_ZERO;
        else if (req_reg.origin_x >= grid_columns || req_reg.origin_y >= grid_rows)
            basic = rpt_pkg::ST_OUTSIDE;
        else if (rx_end > SUM_W'(grid_columns) || ry_end > SUM_W'(grid_rows))
            basic = rpt_pkg::ST_EDGE;
        else
            basic = rpt_pkg::ST_OK;
    end

    // scan: read issue stage, then compare stage on the registered entry
    assign iss = ptr_reg < count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            cmp_v_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            ptr_reg   <= '0;
            cmp_v_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_v_reg <= iss;
            if (iss)
                ptr_reg <= CNT_W'(ptr_reg + 1'b1);
        end
    end

    assign commit = cmd.finish && cmd.fin_status == rpt_pkg::ST_OK && stat.is_place;

    always_ff @(posedge clk)
    begin
        if (cmd.scan && iss)
            rd_reg <= mem[ptr_reg[IDX_W-1:0]];
        if (commit)
            mem[count_reg[IDX_W-1:0]] <= '{h: req_reg.span_h, w: req_reg.span_w,
                                           y: req_reg.origin_y, x: req_reg.origin_x};
    end

    assign ex_end  = SUM_W'(rd_reg.x) + SUM_W'(rd_reg.w);
    assign ey_end  = SUM_W'(rd_reg.y) + SUM_W'(rd_reg.h);
    assign crossed = SUM_W'(rd_reg.x) < rx_end && SUM_W'(req_reg.origin_x) < ex_end &&
                     SUM_W'(rd_reg.y) < ry_end && SUM_W'(req_reg.origin_y) < ey_end;

    assign stat = '{is_clear: req_reg.opcode == rpt_pkg::OP_CLEAR,
                    is_place: req_reg.opcode == rpt_pkg::OP_PLACE,
                    basic:    basic,
                    full:     count_reg >= CNT_MAX,
                    hit:      cmp_v_reg && crossed,
                    drained:  !iss};

    always_comb
    begin
        count_next = count_reg;
        tally_next = tally_reg;
        if (cmd.fin_status == rpt_pkg::ST_CLEARED)
        begin
            count_next = '0;
            tally_next = '0;
        end
        else if (stat.is_place)
        begin
            if (cmd.fin_status == rpt_pkg::ST_OK)
                count_next = CNT_W'(count_reg + 1'b1);
            else if (tally_reg != TALLY_SAT)
                tally_next = rpt_pkg::TALLY_W'(tally_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tally_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                count_reg <= count_next;
                tally_reg <= tally_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.status         <= cmd.fin_status;
            rsp_reg.stored_count   <= rpt_pkg::FIELD_W'(count_next);
            rsp_reg.rejected_count <= tally_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> hdl/rpt_ctrl.sv
// controller state machine: accept, range judge, table scan, finish
// depends on rpt_pkg; commands rpt_dp

module rpt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rpt_pkg::dp_stat_t  stat,
    output rpt_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_JUDGE = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.fin_status = rpt_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                if (stat.is_clear)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = rpt_pkg::ST_CLEARED;
                    state_next     = S_IDLE;
                end
                else if (stat.basic != rpt_pkg::ST_OK)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = stat.basic;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = rpt_pkg::ST_OVERLAP;
                    state_next     = S_IDLE;
                end
                else if (stat.drained)
                begin
                    // fill level only matters to a place that otherwise fits
                    cmd.finish     = 1'b1;
                    cmd.fin_status = (stat.is_place && stat.full) ? rpt_pkg::ST_FULL
                                                                  : rpt_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != S_IDLE;

endmodule

>>> hdl/rectangle_placement_table.sv
// rectangle placement table: one result beat per request, done high for one cycle
// a clear or a range reject finishes in the judge state; otherwise the scan reads the n
// stored rectangles one entry per cycle, and an overlap ends it early; done is registered
// from that finish, and a new request is taken in the cycle done is high; reset clears the
// table count, reject count and controller; grid size resets to min(32, MAX_GRID)
// the receiver cannot stall; depends on rpt_pkg, rpt_cfg, rpt_ctrl, rpt_dp

module rectangle_placement_table #(
    parameter int MAX_GRID  = 32,
    parameter int MIN_GRID  = 1,
    parameter int MAX_RECTS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          start,
    output logic          busy,
    input  rpt_pkg::req_t req,
    output logic          done,
    output rpt_pkg::rsp_t rsp
);

    logic [rpt_pkg::FIELD_W-1:0] grid_columns;
    logic [rpt_pkg::FIELD_W-1:0] grid_rows;
    rpt_pkg::ctrl_cmd_t          cmd;
    rpt_pkg::dp_stat_t           stat;

    rpt_cfg #(
        .MAX_GRID (MAX_GRID),
        .MIN_GRID (MIN_GRID)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .grid_columns (grid_columns),
        .grid_rows    (grid_rows)
    );

    rpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rpt_dp #(
        .MAX_RECTS (MAX_RECTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .grid_columns (grid_columns),
        .grid_rows    (grid_rows),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .rsp          (rsp)
    );

endmodule
